[rtl/core/ps2m_pkg.sv]
`default_nettype none
package ps2m_pkg;

  localparam int RUN_MAX = 5;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  // reply bytes
  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
  localparam logic [7:0] ID_PLAIN    = 8'h00;
  localparam logic [7:0] ID_WHEEL    = 8'h03;

  // host commands
  localparam logic [7:0] CMD_RESET      = 8'hFF;
  localparam logic [7:0] CMD_RESEND     = 8'hFE;
  localparam logic [7:0] CMD_DEFAULTS   = 8'hF6;
  localparam logic [7:0] CMD_REPORT_OFF = 8'hF5;
  localparam logic [7:0] CMD_REPORT_ON  = 8'hF4;
  localparam logic [7:0] CMD_SET_RATE   = 8'hF3;
  localparam logic [7:0] CMD_GET_ID     = 8'hF2;
  localparam logic [7:0] CMD_REMOTE     = 8'hF0;
  localparam logic [7:0] CMD_WRAP       = 8'hEE;
  localparam logic [7:0] CMD_WRAP_RESET = 8'hEC;
  localparam logic [7:0] CMD_READ_DATA  = 8'hEB;
  localparam logic [7:0] CMD_STREAM     = 8'hEA;
  localparam logic [7:0] CMD_STATUS     = 8'hE9;
  localparam logic [7:0] CMD_SET_RES    = 8'hE8;
  localparam logic [7:0] CMD_SCALE_21   = 8'hE7;
  localparam logic [7:0] CMD_SCALE_11   = 8'hE6;

  // modes
  localparam logic [1:0] MODE_REMOTE = 2'd0;
  localparam logic [1:0] MODE_STREAM = 2'd1;
  localparam logic [1:0] MODE_WRAP   = 2'd2;

  // pending argument
  localparam logic [1:0] ARG_NONE = 2'd0;
  localparam logic [1:0] ARG_RATE = 2'd1;
  localparam logic [1:0] ARG_RES  = 2'd2;

  localparam logic [7:0] RATE_DEFAULT = 8'd100;
  localparam logic [7:0] RES_DEFAULT  = 8'd2;
  localparam logic [7:0] KNOCK_FIRST  = 8'd200;
  localparam logic [7:0] KNOCK_SECOND = 8'd100;
  localparam logic [7:0] KNOCK_THIRD  = 8'd80;
  localparam logic signed [15:0] OVF_LIMIT = 16'sd255;

  typedef struct packed {
    logic                       push;
    logic [RUN_CNT_W-1:0]       cnt;
    logic [RUN_MAX-1:0][7:0]    bytes;
  } run_t;

endpackage
`default_nettype wire

[rtl/core/ps2m_if.sv]
`default_nettype none
interface ps2m_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         host_byte;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [7:0]  delta_wheel;
  logic               button_left;
  logic               button_right;
  logic               button_middle;

  modport source (
    output valid, operation, host_byte, delta_x, delta_y, delta_wheel,
           button_left, button_right, button_middle,
    input  ready
  );
  modport sink (
    input  valid, operation, host_byte, delta_x, delta_y, delta_wheel,
           button_left, button_right, button_middle,
    output ready
  );
endinterface

interface ps2m_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       last_byte;

  modport source (output valid, reply_byte, last_byte, input ready);
  modport sink (input valid, reply_byte, last_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/ps2m_core.sv]
`default_nettype none
module ps2m_core
  import ps2m_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ps2m_in_if.sink    in_ch,
  input  wire logic  ser_busy,
  output run_t       run
);

  // input register
  logic               in_valid_r;
  logic               op_r;
  logic [7:0]         hb_r;
  logic signed [15:0] dx_r;
  logic signed [15:0] dy_r;
  logic signed [7:0]  dw_r;
  logic [2:0]         btn_r;

  // device state
  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         prev_mode_r, prev_mode_nxt;
  logic [7:0]         rate_r, rate_nxt;
  logic [7:0]         res_r, res_nxt;
  logic               scal_r, scal_nxt;
  logic               rep_r, rep_nxt;
  logic               wheel_r, wheel_nxt;
  logic [2:0][7:0]    hist_r, hist_nxt;
  logic signed [15:0] cx_r, cx_nxt;
  logic signed [15:0] cy_r, cy_nxt;
  logic signed [7:0]  cw_r, cw_nxt;
  logic [1:0]         ovf_r, ovf_nxt;
  logic [2:0]         btns_r, btns_nxt;
  logic [1:0]         await_r, await_nxt;

  logic               commit;
  logic               in_fire;
  logic [RUN_CNT_W-1:0]    cnt;
  logic [RUN_MAX-1:0][7:0] bytes;
  logic signed [16:0] sum_x, sum_y;
  logic signed [8:0]  sum_w;
  logic signed [15:0] sat_x, sat_y;
  logic signed [7:0]  sat_w;
  logic [15:0]        pkt_x, pkt_y;
  logic               knock;

  function automatic logic [15:0] scale_axis(input logic signed [15:0] v);
    logic [15:0] mag;
    logic [15:0] r;
    mag = v[15] ? 16'(-v) : 16'(v);
    unique case (mag)
      16'd2:   r = 16'd1;
      16'd4:   r = 16'd6;
      16'd5:   r = 16'd9;
      default: r = (mag <= 16'd3) ? mag : {mag[14:0], 1'b0};
    endcase
    return v[15] ? 16'(-r) : r;
  endfunction

  assign commit       = in_valid_r && ((cnt == '0) || !ser_busy);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !in_valid_r || commit;
  assign run.push     = commit && (cnt != '0);
  assign run.cnt      = cnt;
  assign run.bytes    = bytes;

  // saturating accumulation
  assign sum_x = 17'(cx_r) + 17'(dx_r);
  assign sum_y = 17'(cy_r) + 17'(dy_r);
  assign sum_w = 9'(cw_r) + 9'(dw_r);
  assign sat_x = (sum_x[16] != sum_x[15]) ? (sum_x[16] ? 16'sh8000 : 16'sh7FFF) : sum_x[15:0];
  assign sat_y = (sum_y[16] != sum_y[15]) ? (sum_y[16] ? 16'sh8000 : 16'sh7FFF) : sum_y[15:0];
  assign sat_w = (sum_w[8] != sum_w[7]) ? (sum_w[8] ? 8'sh80 : 8'sh7F) : sum_w[7:0];

  assign pkt_x = scal_r ? scale_axis(cx_r) : cx_r;
  assign pkt_y = scal_r ? scale_axis(cy_r) : cy_r;
  assign knock = (hist_r[0] == KNOCK_FIRST) && (hist_r[1] == KNOCK_SECOND)
                 && (hist_r[2] == KNOCK_THIRD);

  always_comb begin
    mode_nxt      = mode_r;
    prev_mode_nxt = prev_mode_r;
    rate_nxt      = rate_r;
    res_nxt       = res_r;
    scal_nxt      = scal_r;
    rep_nxt       = rep_r;
    wheel_nxt     = wheel_r;
    hist_nxt      = hist_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    ovf_nxt       = ovf_r;
    btns_nxt      = btns_r;
    await_nxt     = await_r;
    cnt           = '0;
    bytes         = '0;
    bytes[0]      = BYTE_ACK;
    if (op_r) begin
      cx_nxt   = sat_x;
      cy_nxt   = sat_y;
      cw_nxt   = sat_w;
      btns_nxt = btn_r;
      if (sat_x > OVF_LIMIT || sat_x < -OVF_LIMIT) ovf_nxt[0] = 1'b1;
      if (sat_y > OVF_LIMIT || sat_y < -OVF_LIMIT) ovf_nxt[1] = 1'b1;
    end else begin
      await_nxt = ARG_NONE;
      priority if (await_r == ARG_RATE) begin
        rate_nxt = (hb_r == 8'd0) ? RATE_DEFAULT : hb_r;
        hist_nxt = {hb_r, hist_r[2], hist_r[1]};
        cnt      = RUN_CNT_W'(1);
        cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
      end else if (await_r == ARG_RES) begin
        res_nxt = hb_r;
        cnt     = RUN_CNT_W'(1);
        cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
      end else if (mode_r == MODE_WRAP) begin
        cnt = RUN_CNT_W'(1);
        if (hb_r == CMD_WRAP || hb_r == CMD_WRAP_RESET) begin
          cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          if (hb_r == CMD_WRAP_RESET) begin
            prev_mode_nxt = mode_r;
            mode_nxt      = prev_mode_r;
          end
        end else begin
          bytes[0] = hb_r;  // echo
        end
      end else begin
        unique case (hb_r)
          CMD_RESET: begin
            cnt      = RUN_CNT_W'(3);
            bytes[1] = BYTE_BAT_OK;
            bytes[2] = 8'h00;
            wheel_nxt = 1'b0;
            rate_nxt = RATE_DEFAULT; res_nxt = RES_DEFAULT;
            scal_nxt = 1'b0; rep_nxt = 1'b0;
            prev_mode_nxt = mode_r; mode_nxt = MODE_STREAM;
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_RESEND: cnt = RUN_CNT_W'(1);
          CMD_DEFAULTS: begin
            cnt = RUN_CNT_W'(1);
            rate_nxt = RATE_DEFAULT; res_nxt = RES_DEFAULT;
            scal_nxt = 1'b0; rep_nxt = 1'b0;
            prev_mode_nxt = mode_r; mode_nxt = MODE_STREAM;
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_REPORT_OFF, CMD_REPORT_ON: begin
            cnt = RUN_CNT_W'(1);
            rep_nxt = (hb_r == CMD_REPORT_ON);
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_SET_RATE: begin
            cnt = RUN_CNT_W'(1);
            await_nxt = ARG_RATE;
          end
          CMD_GET_ID: begin
            cnt       = RUN_CNT_W'(2);
            wheel_nxt = knock;
            bytes[1]  = knock ? ID_WHEEL : ID_PLAIN;
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_REMOTE, CMD_WRAP, CMD_STREAM: begin
            cnt = RUN_CNT_W'(1);
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
            prev_mode_nxt = mode_r;
            mode_nxt = (hb_r == CMD_REMOTE) ? MODE_REMOTE
                     : ((hb_r == CMD_WRAP) ? MODE_WRAP : MODE_STREAM);
          end
          CMD_WRAP_RESET: begin
            cnt = RUN_CNT_W'(1);
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_READ_DATA: begin
            cnt      = wheel_r ? RUN_CNT_W'(5) : RUN_CNT_W'(4);
            bytes[1] = {ovf_r[1], ovf_r[0], pkt_y[8], pkt_x[8], 1'b1, btns_r};
            bytes[2] = pkt_x[7:0];
            bytes[3] = pkt_y[7:0];
            bytes[4] = {4'h0, cw_r[3:0]};
            cx_nxt = '0; cy_nxt = '0; cw_nxt = '0; ovf_nxt = '0;
          end
          CMD_STATUS: begin
            cnt      = RUN_CNT_W'(4);
            bytes[1] = {1'b0, (mode_r == MODE_REMOTE), rep_r, scal_r, 1'b0,
                        btns_r[0], btns_r[2], btns_r[1]};
            bytes[2] = res_r;
            bytes[3] = rate_r;
          end
          CMD_SET_RES: begin
            cnt = RUN_CNT_W'(1);
            await_nxt = ARG_RES;
          end
          CMD_SCALE_21, CMD_SCALE_11: begin
            cnt = RUN_CNT_W'(1);
            scal_nxt = (hb_r == CMD_SCALE_21);
          end
          default: cnt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (commit) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.operation;
      hb_r  <= in_ch.host_byte;
      dx_r  <= in_ch.delta_x;
      dy_r  <= in_ch.delta_y;
      dw_r  <= in_ch.delta_wheel;
      btn_r <= {in_ch.button_middle, in_ch.button_right, in_ch.button_left};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STREAM;
      prev_mode_r <= MODE_STREAM;
      rate_r      <= RATE_DEFAULT;
      res_r       <= RES_DEFAULT;
      scal_r      <= 1'b0;
      rep_r       <= 1'b0;
      wheel_r     <= 1'b0;
      hist_r      <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      cw_r        <= '0;
      ovf_r       <= '0;
      btns_r      <= '0;
      await_r     <= ARG_NONE;
    end else if (commit) begin
      mode_r      <= mode_nxt;
      prev_mode_r <= prev_mode_nxt;
      rate_r      <= rate_nxt;
      res_r       <= res_nxt;
      scal_r      <= scal_nxt;
      rep_r       <= rep_nxt;
      wheel_r     <= wheel_nxt;
      hist_r      <= hist_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cw_r        <= cw_nxt;
      ovf_r       <= ovf_nxt;
      btns_r      <= btns_nxt;
      await_r     <= await_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_into_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run.push |-> !ser_busy)
    else $error("reply run pushed while serialiser busy");
  a_update_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r) |=> ($stable(mode_r) && $stable(await_r) && $stable(rate_r)))
    else $error("movement update changed protocol state");
`endif

endmodule
`default_nettype wire

[rtl/core/ps2m_serializer.sv]
`default_nettype none
module ps2m_serializer
  import ps2m_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  run_t       run,
  output logic       busy,
  ps2m_out_if.source out_ch
);

  logic                    busy_r;
  logic [RUN_CNT_W-1:0]    cnt_r;
  logic [RUN_IDX_W-1:0]    idx_r;
  logic [RUN_MAX-1:0][7:0] bytes_r;
  logic                    last;
  logic                    out_fire;

  assign busy             = busy_r;
  assign last             = (RUN_CNT_W'(idx_r) == cnt_r - RUN_CNT_W'(1));
  assign out_fire         = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = busy_r;
  assign out_ch.reply_byte = bytes_r[idx_r];
  assign out_ch.last_byte = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (run.push) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RUN_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run.push) begin
      cnt_r   <= run.cnt;
      bytes_r <= run.bytes;
    end
  end

`ifndef ASSERT_OFF
  a_index_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0 && RUN_CNT_W'(idx_r) < cnt_r))
    else $error("reply index outside run");
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && last && !run.push) |=> !busy_r)
    else $error("serialiser still busy after last byte");
`endif

endmodule
`default_nettype wire

[rtl/core/ps2_mouse_command_responder_top.sv]
// a request waits in the input register until the serialiser is free; its reply run is
// then loaded into the serialiser and sent one byte per cycle while out_ch.ready is high;
// requests without replies (movement updates, unknown commands) go through at one per cycle
// reset: synchronous active low; stream mode, defaults, counts and rate history cleared
`default_nettype none
module ps2_mouse_command_responder_top
  import ps2m_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ps2m_in_if.sink    in_ch,
  ps2m_out_if.source out_ch
);

  run_t run;
  logic ser_busy;

  ps2m_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ser_busy (ser_busy),
    .run      (run)
  );

  ps2m_serializer u_ser (
    .clk    (clk),
    .rst_n  (rst_n),
    .run    (run),
    .busy   (ser_busy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
